/* sv/event_transition_histogram_core_defines.svh */
// ----------------------------------------------------------------------------
// Event transition histogram assertion macros
// Concurrent assertion wrappers clocked on clk_i, empty in synthesis.
// ----------------------------------------------------------------------------
`ifndef EVENT_TRANSITION_HISTOGRAM_CORE_DEFINES_SVH
`define EVENT_TRANSITION_HISTOGRAM_CORE_DEFINES_SVH

`ifndef SYNTHESIS
// checked only out of reset
`define ETH_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
// checked during reset too
`define ETH_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);
`else
`define ETH_ASSERT(lbl, prop, msg)
`define ETH_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

/* sv/eth_pkg.sv */
// ----------------------------------------------------------------------------
// Event transition histogram package
// Payload types, operation codes and saturating helpers.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package eth_pkg;

  localparam int unsigned OP_W    = 2;
  localparam int unsigned PART_W  = 10;
  localparam int unsigned CLASS_W = 3;
  localparam int unsigned KIND_W  = 3;
  localparam int unsigned TIME_W  = 48;
  localparam int unsigned CNT_W   = 32;
  localparam int unsigned SUM_W   = 56;

  localparam logic [OP_W-1:0] OP_RECORD     = 2'd0;
  localparam logic [OP_W-1:0] OP_READ_CELL  = 2'd1;
  localparam logic [OP_W-1:0] OP_READ_FIRST = 2'd2;

  localparam logic [CLASS_W-1:0] CLASS_NONE = '0;

  localparam logic [CNT_W-1:0] CNT_MAX = '1;
  localparam logic [SUM_W-1:0] SUM_MAX = '1;

  typedef struct packed {
    logic [OP_W-1:0]    operation;
    logic [PART_W-1:0]  particle;
    logic [CLASS_W-1:0] event_class;
    logic [KIND_W-1:0]  event_kind;
    logic [CLASS_W-1:0] prior_class;
    logic [KIND_W-1:0]  prior_kind;
    logic [TIME_W-1:0]  timestamp;
  } req_t;

  typedef struct packed {
    logic [CNT_W-1:0] cell_count;
    logic [SUM_W-1:0] cell_time;
    logic [CNT_W-1:0] first_count;
    logic [CNT_W-1:0] grand_total;
  } rsp_t;

  // per-particle entry: last key and its time
  typedef struct packed {
    logic [CLASS_W-1:0] prior_class;
    logic [KIND_W-1:0]  prior_kind;
    logic [TIME_W-1:0]  prior_time;
  } entry_t;

  // histogram cell
  typedef struct packed {
    logic [CNT_W-1:0] count;
    logic [SUM_W-1:0] time_sum;
  } pair_t;

  function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
    return (v == CNT_MAX) ? v : v + CNT_W'(1);
  endfunction

  function automatic logic [SUM_W-1:0] sat_add(input logic [SUM_W-1:0] a,
                                               input logic [TIME_W-1:0] b);
    logic [SUM_W:0] sum;
    sum = {1'b0, a} + (SUM_W + 1)'(b);
    return sum[SUM_W] ? SUM_MAX : sum[SUM_W-1:0];
  endfunction

endpackage

`default_nettype wire

/* sv/eth_stream_if.sv */
// ----------------------------------------------------------------------------
// Event transition histogram stream interface
// Valid/ready channel carrying one payload item per handshake.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface eth_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

/* sv/eth_ram.sv */
// ----------------------------------------------------------------------------
// Event transition histogram RAM
// Simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module eth_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     wr_en_i,
  input  logic [$clog2(DEPTH)-1:0] wr_addr_i,
  input  logic [WIDTH-1:0]         wr_data_i,
  input  logic                     rd_en_i,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_i,
  output logic [WIDTH-1:0]         rd_data_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    // hold read data when no read is issued
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

`default_nettype wire

/* sv/event_transition_histogram_core.sv */
// ----------------------------------------------------------------------------
// Event transition histogram core
// Read item: result registered in update after lookup, held while stalled.
// A new item is accepted in idle or as the last one leaves update; each takes
// the particle table read, then the read-modify-write of the pair cell. Reset
// clears max(PARTICLES, KEYS*KEYS) entries (4096 by default), no item accepted.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "event_transition_histogram_core_defines.svh"

module event_transition_histogram_core #(
  parameter int unsigned PARTICLES   = 1024,
  parameter int unsigned CLASS_CODES = 8,
  parameter int unsigned EVENT_KINDS = 8
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  eth_stream_if.sink   req_i,
  eth_stream_if.source rsp_o
);

  localparam int unsigned KEYS      = CLASS_CODES * EVENT_KINDS;
  localparam int unsigned CELLS     = KEYS * KEYS;
  localparam int unsigned PW        = $clog2(PARTICLES);
  localparam int unsigned KW        = $clog2(KEYS);
  localparam int unsigned CW        = $clog2(CELLS);
  localparam int unsigned CLR_DEPTH = (PARTICLES > CELLS) ? PARTICLES : CELLS;
  localparam int unsigned CLRW      = $clog2(CLR_DEPTH);
  localparam int unsigned ENTRY_W   = $bits(eth_pkg::entry_t);
  localparam int unsigned PAIR_W    = $bits(eth_pkg::pair_t);

  typedef enum logic [3:0] {
    ST_CLEAR  = 4'b0001,
    ST_IDLE   = 4'b0010,
    ST_LOOKUP = 4'b0100,
    ST_UPDATE = 4'b1000
  } state_e;

  function automatic logic key_ok(input logic [eth_pkg::CLASS_W-1:0] c,
                                  input logic [eth_pkg::KIND_W-1:0] k);
    return (32'(c) < CLASS_CODES) && (32'(k) < EVENT_KINDS);
  endfunction

  function automatic logic [KW-1:0] key_idx(input logic [eth_pkg::CLASS_W-1:0] c,
                                            input logic [eth_pkg::KIND_W-1:0] k);
    return KW'(32'(c) * EVENT_KINDS + 32'(k));
  endfunction

  function automatic logic [CW-1:0] cell_idx(input logic [KW-1:0] n,
                                             input logic [KW-1:0] p);
    return CW'(32'(n) * KEYS + 32'(p));
  endfunction

  state_e                        state_q, state_d;
  logic [CLRW-1:0]               clr_cnt_q, clr_cnt_d;
  eth_pkg::req_t                 req_q;
  logic                          rec_ok_q, has_prior_q, cell_ok_q, first_ok_q;
  logic [eth_pkg::TIME_W-1:0]    dt_q;
  logic [CW-1:0]                 cell_q;
  logic [KW-1:0]                 nk_q;
  logic [eth_pkg::CNT_W-1:0]     tot_q, tot_d;
  logic                          out_valid_q, out_valid_d;
  eth_pkg::rsp_t                 out_q, out_d;

  logic accept, out_free, is_read, upd_done, load_out;

  // particle table port
  logic               part_we, part_re;
  logic [PW-1:0]      part_waddr, part_raddr;
  eth_pkg::entry_t    part_wdata, part_rdata;

  // pair table port
  logic               pair_we, pair_re;
  logic [CW-1:0]      pair_waddr, pair_raddr;
  eth_pkg::pair_t     pair_wdata, pair_rdata;

  // first-event table port
  logic                      first_we, first_re;
  logic [KW-1:0]             first_waddr, first_raddr;
  logic [eth_pkg::CNT_W-1:0] first_wdata, first_rdata;

  // lookup-stage values
  logic          lk_new_ok, lk_prior_ok, lk_part_ok, lk_rec_ok, lk_has_prior;
  logic [KW-1:0] lk_nk, lk_rk, lk_pk;
  logic [eth_pkg::TIME_W-1:0] lk_dt;

  logic clr_last;

  assign accept   = req_i.valid && req_i.ready;
  assign out_free = !out_valid_q || rsp_o.ready;
  assign is_read  = (req_q.operation == eth_pkg::OP_READ_CELL) ||
                    (req_q.operation == eth_pkg::OP_READ_FIRST);
  assign upd_done = !is_read || out_free;
  assign load_out = (state_q == ST_UPDATE) && is_read && out_free;
  assign clr_last = (clr_cnt_q == CLRW'(CLR_DEPTH - 1));

  assign req_i.ready = (state_q == ST_IDLE) || ((state_q == ST_UPDATE) && upd_done);
  assign rsp_o.valid   = out_valid_q;
  assign rsp_o.payload = out_q;

  // lookup: previous key of the particle is on the particle table output
  always_comb begin
    lk_new_ok    = key_ok(req_q.event_class, req_q.event_kind);
    lk_prior_ok  = key_ok(req_q.prior_class, req_q.prior_kind);
    lk_part_ok   = 32'(req_q.particle) < PARTICLES;
    lk_rec_ok    = (req_q.operation == eth_pkg::OP_RECORD) && lk_part_ok && lk_new_ok;
    lk_has_prior = part_rdata.prior_class != eth_pkg::CLASS_NONE;
    lk_nk        = key_idx(req_q.event_class, req_q.event_kind);
    lk_rk        = key_idx(req_q.prior_class, req_q.prior_kind);
    lk_pk        = key_idx(part_rdata.prior_class, part_rdata.prior_kind);
    lk_dt        = (req_q.timestamp >= part_rdata.prior_time) ?
                   req_q.timestamp - part_rdata.prior_time : '0;
  end

  // table accesses
  always_comb begin
    part_re    = accept;
    part_raddr = PW'(req_i.payload.particle);
    part_we    = 1'b0;
    part_waddr = PW'(req_q.particle);
    part_wdata = '{prior_class: req_q.event_class, prior_kind: req_q.event_kind,
                   prior_time: req_q.timestamp};

    pair_re    = state_q == ST_LOOKUP;
    pair_raddr = (req_q.operation == eth_pkg::OP_RECORD) ?
                 cell_idx(lk_nk, lk_pk) : cell_idx(lk_nk, lk_rk);
    pair_we    = 1'b0;
    pair_waddr = cell_q;
    pair_wdata = '{count: eth_pkg::sat_inc(pair_rdata.count),
                   time_sum: eth_pkg::sat_add(pair_rdata.time_sum, dt_q)};

    first_re    = state_q == ST_LOOKUP;
    first_raddr = lk_nk;
    first_we    = 1'b0;
    first_waddr = nk_q;
    first_wdata = eth_pkg::sat_inc(first_rdata);

    tot_d = tot_q;

    unique case (state_q)
      ST_CLEAR: begin
        part_we     = 32'(clr_cnt_q) < PARTICLES;
        part_waddr  = PW'(clr_cnt_q);
        part_wdata  = '0;
        pair_we     = 32'(clr_cnt_q) < CELLS;
        pair_waddr  = CW'(clr_cnt_q);
        pair_wdata  = '0;
        first_we    = 32'(clr_cnt_q) < KEYS;
        first_waddr = KW'(clr_cnt_q);
        first_wdata = '0;
      end
      ST_LOOKUP: begin
        part_we = lk_rec_ok;
      end
      ST_UPDATE: begin
        pair_we  = rec_ok_q && has_prior_q;
        first_we = rec_ok_q && !has_prior_q;
        if (rec_ok_q && has_prior_q) begin
          tot_d = eth_pkg::sat_inc(tot_q);
        end
      end
      default: begin
      end
    endcase
  end

  // result
  always_comb begin
    out_valid_d = out_valid_q;
    out_d       = out_q;
    if (load_out) begin
      out_valid_d       = 1'b1;
      out_d.cell_count  = '0;
      out_d.cell_time   = '0;
      out_d.first_count = '0;
      out_d.grand_total = tot_q;
      if ((req_q.operation == eth_pkg::OP_READ_CELL) && cell_ok_q) begin
        out_d.cell_count = pair_rdata.count;
        out_d.cell_time  = pair_rdata.time_sum;
      end
      if ((req_q.operation == eth_pkg::OP_READ_FIRST) && first_ok_q) begin
        out_d.first_count = first_rdata;
      end
    end else if (rsp_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_comb begin
    state_d   = state_q;
    clr_cnt_d = clr_cnt_q;
    unique case (state_q)
      ST_CLEAR: begin
        clr_cnt_d = clr_cnt_q + CLRW'(1);
        if (clr_last) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          state_d = ST_LOOKUP;
        end
      end
      ST_LOOKUP: begin
        state_d = ST_UPDATE;
      end
      ST_UPDATE: begin
        if (upd_done) begin
          state_d = accept ? ST_LOOKUP : ST_IDLE;
        end
      end
      default: begin
        state_d = ST_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_cnt_q   <= '0;
      tot_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_cnt_q   <= clr_cnt_d;
      tot_q       <= tot_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
    if (accept) begin
      req_q <= req_i.payload;
    end
    if (state_q == ST_LOOKUP) begin
      rec_ok_q    <= lk_rec_ok;
      has_prior_q <= lk_has_prior;
      cell_ok_q   <= lk_new_ok && lk_prior_ok;
      first_ok_q  <= lk_new_ok;
      dt_q        <= lk_dt;
      cell_q      <= pair_raddr;
      nk_q        <= lk_nk;
    end
  end

  eth_ram #(.WIDTH(ENTRY_W), .DEPTH(PARTICLES)) u_part_ram (
    .clk_i     (clk_i),
    .wr_en_i   (part_we),
    .wr_addr_i (part_waddr),
    .wr_data_i (part_wdata),
    .rd_en_i   (part_re),
    .rd_addr_i (part_raddr),
    .rd_data_o (part_rdata)
  );

  eth_ram #(.WIDTH(PAIR_W), .DEPTH(CELLS)) u_pair_ram (
    .clk_i     (clk_i),
    .wr_en_i   (pair_we),
    .wr_addr_i (pair_waddr),
    .wr_data_i (pair_wdata),
    .rd_en_i   (pair_re),
    .rd_addr_i (pair_raddr),
    .rd_data_o (pair_rdata)
  );

  eth_ram #(.WIDTH(eth_pkg::CNT_W), .DEPTH(KEYS)) u_first_ram (
    .clk_i     (clk_i),
    .wr_en_i   (first_we),
    .wr_addr_i (first_waddr),
    .wr_data_i (first_wdata),
    .rd_en_i   (first_re),
    .rd_addr_i (first_raddr),
    .rd_data_o (first_rdata)
  );

  `ETH_ASSERT(a_accept_to_lookup, accept |=> (state_q == ST_LOOKUP), "accepted item did not enter lookup")
  `ETH_ASSERT(a_rsp_from_update, $rose(out_valid_q) |-> $past(state_q == ST_UPDATE), "result raised outside update")
  `ETH_ASSERT(a_total_from_record, (tot_q != $past(tot_q)) |-> $past((state_q == ST_UPDATE) && rec_ok_q && has_prior_q), "total changed without a transition")
  `ETH_ASSERT(a_part_wr_follows_accept, (part_we && (state_q == ST_LOOKUP)) |-> $past(accept), "particle write without an accepted record")
  `ETH_ASSERT_ALWAYS(a_no_accept_in_clear, (state_q == ST_CLEAR) |-> !req_i.ready, "ready during clearing pass")

endmodule

`default_nettype wire

/* test/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Event transition histogram core testbench
// Drives record and read items over the request stream, predicts every read
// result from a behavioral copy of the particle table and the histogram, and
// checks each result field by field. Phases vary sender and receiver idling.
// ----------------------------------------------------------------------------

module tb_top;
  import eth_pkg::*;

  localparam int unsigned NUM_PARTICLES = 1024;
  localparam int unsigned NUM_CLASSES   = 8;
  localparam int unsigned NUM_KINDS     = 8;
  localparam int unsigned NUM_KEYS      = NUM_CLASSES * NUM_KINDS;
  localparam int unsigned NUM_CELLS     = NUM_KEYS * NUM_KEYS;
  localparam int          CYCLE_LIMIT   = 400000;
  localparam int          MAX_REPORTS   = 10;

  localparam logic [OP_W-1:0]   OP_UNUSED = 2'd3;
  localparam logic [TIME_W-1:0] STAMP_MAX = '1;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  always #6 clk_i = ~clk_i;

  eth_stream_if #(.payload_t(req_t)) req_if ();
  eth_stream_if #(.payload_t(rsp_t)) rsp_if ();

  logic drv_valid = 1'b0;
  req_t drv_item  = '0;
  logic mon_ready = 1'b0;

  assign req_if.valid   = drv_valid;
  assign req_if.payload = drv_item;
  assign rsp_if.ready   = mon_ready;

  event_transition_histogram_core dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .rsp_o  (rsp_if)
  );

  // behavioral copy of the block state
  logic [CLASS_W-1:0] last_class [NUM_PARTICLES];
  logic [KIND_W-1:0]  last_kind  [NUM_PARTICLES];
  logic [TIME_W-1:0]  last_stamp [NUM_PARTICLES];
  logic [CNT_W-1:0]   cell_hits  [NUM_CELLS];
  logic [SUM_W-1:0]   cell_sum   [NUM_CELLS];
  logic [CNT_W-1:0]   first_hits [NUM_KEYS];
  logic [CNT_W-1:0]   total_hits;

  req_t pending_req_q [$];
  rsp_t expected_rsp_q [$];

  int src_idle_pct = 0;
  int snk_idle_pct = 0;
  int error_count  = 0;
  int rsp_seen     = 0;
  int cycle_count  = 0;
  logic [TIME_W-1:0] stamp_now = '0;

  function automatic bit key_valid(input logic [CLASS_W-1:0] c, input logic [KIND_W-1:0] k);
    return (c < NUM_CLASSES) && (k < NUM_KINDS);
  endfunction

  function automatic int unsigned key_of(input logic [CLASS_W-1:0] c,
                                         input logic [KIND_W-1:0] k);
    return int'(c) * NUM_KINDS + int'(k);
  endfunction

  // update the histogram copy and queue the result a read item produces
  function automatic void apply_to_histogram(input req_t it);
    int unsigned       new_key;
    int unsigned       cell_ix;
    logic [TIME_W-1:0] dt;
    logic [SUM_W:0]    sum;
    rsp_t              r;
    r = '0;
    case (it.operation)
      OP_RECORD: begin
        if (it.particle < NUM_PARTICLES && key_valid(it.event_class, it.event_kind)) begin
          new_key = key_of(it.event_class, it.event_kind);
          if (last_class[it.particle] != CLASS_NONE) begin
            cell_ix = new_key * NUM_KEYS
                    + key_of(last_class[it.particle], last_kind[it.particle]);
            dt = (it.timestamp >= last_stamp[it.particle]) ?
                 it.timestamp - last_stamp[it.particle] : '0;
            sum = {1'b0, cell_sum[cell_ix]} + {{(SUM_W + 1 - TIME_W){1'b0}}, dt};
            cell_sum[cell_ix] = sum[SUM_W] ? SUM_MAX : sum[SUM_W-1:0];
            if (cell_hits[cell_ix] != CNT_MAX) cell_hits[cell_ix] = cell_hits[cell_ix] + 1;
            if (total_hits != CNT_MAX) total_hits = total_hits + 1;
          end else begin
            if (first_hits[new_key] != CNT_MAX) first_hits[new_key] = first_hits[new_key] + 1;
          end
          last_stamp[it.particle] = it.timestamp;
          last_class[it.particle] = it.event_class;
          last_kind[it.particle]  = it.event_kind;
        end
      end
      OP_READ_CELL: begin
        if (key_valid(it.event_class, it.event_kind) &&
            key_valid(it.prior_class, it.prior_kind)) begin
          cell_ix = key_of(it.event_class, it.event_kind) * NUM_KEYS
                  + key_of(it.prior_class, it.prior_kind);
          r.cell_count = cell_hits[cell_ix];
          r.cell_time  = cell_sum[cell_ix];
        end
        r.grand_total = total_hits;
        expected_rsp_q.push_back(r);
      end
      OP_READ_FIRST: begin
        if (key_valid(it.event_class, it.event_kind))
          r.first_count = first_hits[key_of(it.event_class, it.event_kind)];
        r.grand_total = total_hits;
        expected_rsp_q.push_back(r);
      end
      default: ;
    endcase
  endfunction

  function automatic void flag_error(input string msg);
    if (error_count < MAX_REPORTS) $display("[%0t] ERROR: %s", $realtime, msg);
    error_count++;
  endfunction

  // request driver: hold valid until the item is taken
  always @(posedge clk_i) begin : req_driver
    if (rst_ni) begin
      if (drv_valid && req_if.ready) begin
        apply_to_histogram(drv_item);
        void'(pending_req_q.pop_front());
      end
      if (!drv_valid || req_if.ready) begin
        if (pending_req_q.size() > 0 && $urandom_range(99) >= src_idle_pct) begin
          drv_valid <= 1'b1;
          drv_item  <= pending_req_q[0];
        end else begin
          drv_valid <= 1'b0;
        end
      end
    end
  end

  // result monitor
  always @(posedge clk_i) begin : rsp_monitor
    rsp_t want;
    rsp_t got;
    if (rst_ni) begin
      if (rsp_if.valid && mon_ready) begin
        got = rsp_if.payload;
        if (expected_rsp_q.size() == 0) begin
          flag_error($sformatf("result with nothing expected: count=%0h time=%0h first=%0h total=%0h",
                               got.cell_count, got.cell_time, got.first_count, got.grand_total));
        end else begin
          want = expected_rsp_q.pop_front();
          if (got.cell_count !== want.cell_count || got.cell_time !== want.cell_time ||
              got.first_count !== want.first_count || got.grand_total !== want.grand_total)
            flag_error($sformatf({"result %0d: expected count=%0h time=%0h first=%0h ",
                                  "total=%0h, got count=%0h time=%0h first=%0h total=%0h"},
                                 rsp_seen, want.cell_count, want.cell_time, want.first_count,
                                 want.grand_total, got.cell_count, got.cell_time,
                                 got.first_count, got.grand_total));
        end
        rsp_seen++;
      end
      mon_ready <= ($urandom_range(99) >= snk_idle_pct);
    end else begin
      mon_ready <= 1'b0;
    end
  end

  always @(posedge clk_i) cycle_count <= cycle_count + 1;

  initial begin : watchdog
    while (cycle_count < CYCLE_LIMIT) @(posedge clk_i);
    $display("== FAIL ==");
    $finish;
  end

  task automatic push_item(input logic [OP_W-1:0] op, input logic [PART_W-1:0] part,
                           input logic [CLASS_W-1:0] cls, input logic [KIND_W-1:0] kind,
                           input logic [CLASS_W-1:0] pcls, input logic [KIND_W-1:0] pkind,
                           input logic [TIME_W-1:0] ts);
    req_t it;
    it.operation   = op;
    it.particle    = part;
    it.event_class = cls;
    it.event_kind  = kind;
    it.prior_class = pcls;
    it.prior_kind  = pkind;
    it.timestamp   = ts;
    pending_req_q.push_back(it);
  endtask

  function automatic logic [TIME_W-1:0] rand_stamp();
    logic [63:0] w;
    w = {$urandom, $urandom};
    return w[TIME_W-1:0];
  endfunction

  task automatic wait_drained();
    while (pending_req_q.size() != 0 || drv_valid || expected_rsp_q.size() != 0)
      @(negedge clk_i);
  endtask

  // random mix over a small set of particles and keys so that cells repeat
  task automatic gen_random(input int n);
    logic [PART_W-1:0]  pool_part [12];
    logic [5:0]         pool_key  [4];
    int                 r;
    int                 s;
    logic [PART_W-1:0]  p;
    logic [5:0]         k;
    logic [5:0]         pk;
    logic [TIME_W-1:0]  ts;
    foreach (pool_part[i]) pool_part[i] = PART_W'($urandom);
    foreach (pool_key[i]) pool_key[i] = 6'($urandom);
    for (int i = 0; i < n; i++) begin
      r  = $urandom_range(99);
      k  = ($urandom_range(99) < 85) ? pool_key[$urandom_range(3)] : 6'($urandom);
      pk = ($urandom_range(99) < 85) ? pool_key[$urandom_range(3)] : 6'($urandom);
      p  = ($urandom_range(99) < 90) ? pool_part[$urandom_range(11)] : PART_W'($urandom);
      if (r < 50) begin
        s = $urandom_range(99);
        if (s < 80) begin
          stamp_now = stamp_now + TIME_W'($urandom_range(1000));
          ts = stamp_now;
        end else if (s < 88) begin
          ts = rand_stamp();
        end else if (s < 95) begin
          ts = stamp_now - TIME_W'($urandom_range(5000));
        end else begin
          ts = STAMP_MAX;
        end
        push_item(OP_RECORD, p, k[5:3], k[2:0], 3'($urandom), 3'($urandom), ts);
      end else if (r < 75) begin
        push_item(OP_READ_CELL, PART_W'($urandom), k[5:3], k[2:0], pk[5:3], pk[2:0],
                  rand_stamp());
      end else if (r < 92) begin
        push_item(OP_READ_FIRST, PART_W'($urandom), k[5:3], k[2:0], 3'($urandom),
                  3'($urandom), rand_stamp());
      end else if (r < 96) begin
        push_item(OP_UNUSED, PART_W'($urandom), 3'($urandom), 3'($urandom), 3'($urandom),
                  3'($urandom), rand_stamp());
      end else begin
        push_item(OP_RECORD, PART_W'($urandom), 3'($urandom), 3'($urandom), 3'($urandom),
                  3'($urandom), rand_stamp());
      end
    end
  endtask

  initial begin : stimulus
    logic [PART_W-1:0] p;
    for (int i = 0; i < NUM_PARTICLES; i++) begin
      last_class[i] = CLASS_NONE;
      last_kind[i]  = '0;
      last_stamp[i] = '0;
    end
    for (int i = 0; i < NUM_CELLS; i++) begin
      cell_hits[i] = '0;
      cell_sum[i]  = '0;
    end
    for (int i = 0; i < NUM_KEYS; i++) first_hits[i] = '0;
    total_hits = '0;

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // directed: empty reads, first events, extreme stamps, time going backwards
    push_item(OP_READ_CELL, '0, 3'd0, 3'd0, 3'd0, 3'd0, '0);
    push_item(OP_READ_FIRST, '1, 3'd0, 3'd0, 3'd7, 3'd7, STAMP_MAX);
    push_item(OP_RECORD, '0, 3'd7, 3'd7, 3'd0, 3'd0, '0);
    push_item(OP_RECORD, '0, 3'd1, 3'd0, 3'd7, 3'd7, STAMP_MAX);
    push_item(OP_RECORD, '0, 3'd7, 3'd7, 3'd0, 3'd0, 48'd5);
    push_item(OP_RECORD, '1, 3'd0, 3'd7, 3'd7, 3'd7, 48'd100);
    push_item(OP_RECORD, '1, 3'd3, 3'd5, 3'd0, 3'd0, 48'd50);
    push_item(OP_RECORD, '1, 3'd3, 3'd5, 3'd0, 3'd0, STAMP_MAX);
    push_item(OP_UNUSED, '1, 3'd7, 3'd7, 3'd7, 3'd7, STAMP_MAX);
    push_item(OP_READ_CELL, '0, 3'd1, 3'd0, 3'd7, 3'd7, '0);
    push_item(OP_READ_CELL, '0, 3'd7, 3'd7, 3'd1, 3'd0, '0);
    push_item(OP_READ_CELL, '1, 3'd3, 3'd5, 3'd3, 3'd5, STAMP_MAX);
    push_item(OP_READ_CELL, '1, 3'd7, 3'd7, 3'd7, 3'd7, STAMP_MAX);
    push_item(OP_READ_FIRST, '0, 3'd7, 3'd7, 3'd0, 3'd0, '0);
    push_item(OP_READ_FIRST, '0, 3'd0, 3'd7, 3'd0, 3'd0, '0);
    push_item(OP_READ_FIRST, '1, 3'd3, 3'd5, 3'd7, 3'd7, STAMP_MAX);
    // a none-class event after a real one still counts, then resets the chain
    push_item(OP_RECORD, '0, 3'd0, 3'd3, 3'd0, 3'd0, 48'd10);
    push_item(OP_RECORD, '0, 3'd2, 3'd2, 3'd0, 3'd0, 48'd20);
    push_item(OP_READ_CELL, '0, 3'd0, 3'd3, 3'd7, 3'd7, '0);
    push_item(OP_READ_FIRST, '0, 3'd2, 3'd2, 3'd0, 3'd0, '0);
    push_item(OP_READ_FIRST, '0, 3'd0, 3'd3, 3'd0, 3'd0, '0);
    push_item(OP_READ_CELL, '0, 3'd2, 3'd2, 3'd0, 3'd3, '0);
    gen_random(250);
    wait_drained();

    src_idle_pct = 49;
    snk_idle_pct = 0;
    gen_random(250);
    wait_drained();

    // drive one cell's time sum into saturation: low stamp, then the top stamp
    src_idle_pct = 0;
    snk_idle_pct = 49;
    for (int i = 0; i < 264; i++) begin
      p = PART_W'($urandom);
      push_item(OP_RECORD, p, 3'd7, 3'd6, 3'($urandom), 3'($urandom),
                TIME_W'($urandom_range(15)));
      push_item(OP_RECORD, p, 3'd6, 3'd7, 3'($urandom), 3'($urandom),
                STAMP_MAX - TIME_W'($urandom_range(15)));
      if (i % 20 == 19 || i > 252)
        push_item(OP_READ_CELL, PART_W'($urandom), 3'd6, 3'd7, 3'd7, 3'd6, rand_stamp());
    end
    push_item(OP_READ_CELL, '0, 3'd7, 3'd6, 3'd6, 3'd7, '0);
    push_item(OP_READ_FIRST, '0, 3'd7, 3'd6, 3'd0, 3'd0, '0);
    wait_drained();

    src_idle_pct = 31;
    snk_idle_pct = 31;
    gen_random(500);
    wait_drained();

    repeat (10) @(negedge clk_i);
    if (error_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
